// ===== src/lre_pkg.sv =====
// Shared constants for the linear run encoder.
`timescale 1ns / 1ps
`default_nettype none

package lre_pkg;

	// Run-limit register: width and value after reset
	localparam int unsigned CFG_WIDTH = 16;
	localparam logic [CFG_WIDTH-1:0] CFG_RESET = 16'hFFFF;

	// Result queue holds the most results one transaction can produce
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QCNT_WIDTH = 2;

endpackage

`default_nettype wire

// ===== src/lre_if.sv =====
// Valid/ready channel interfaces for column values and encoded runs.
`timescale 1ns / 1ps
`default_nettype none

interface lre_col_if #(
	parameter int unsigned DATA_WIDTH = 32
);
	logic                  valid;
	logic                  ready;
	logic [DATA_WIDTH-1:0] value;
	logic                  end_of_column;

	modport source (output valid, output value, output end_of_column, input ready);
	modport sink   (input valid, input value, input end_of_column, output ready);
endinterface

interface lre_run_if #(
	parameter int unsigned DATA_WIDTH  = 32,
	parameter int unsigned COUNT_WIDTH = 16
);
	logic                   valid;
	logic                   ready;
	logic [DATA_WIDTH-1:0]  run_base;
	logic [DATA_WIDTH-1:0]  run_step;
	logic [COUNT_WIDTH-1:0] run_count;
	logic [DATA_WIDTH-1:0]  value_sum;
	logic                   last_run;

	modport source (
		output valid, output run_base, output run_step, output run_count,
		output value_sum, output last_run, input ready
	);
	modport sink (
		input valid, input run_base, input run_step, input run_count,
		input value_sum, input last_run, output ready
	);
endinterface

`default_nettype wire

// ===== src/linear_run_encoder_core.sv =====
// Top level: arithmetic-progression run encoder with a two-entry result queue.
`timescale 1ns / 1ps
`default_nettype none

// The encoder gathers column values into runs (base, step, count); a run
// closes when the step breaks, when it reaches max_run_length values, or on
// end_of_column, and each closed run leaves with the wrapped running sum of
// all values up to and including its own last one. A value is first held in
// an input register; from there the run state is updated by a single
// subtract, compare and add and the closed runs enter a two-entry result
// queue, whose head drives the result port. Throughput is one value per
// cycle while the result side takes each run as offered; a value that both
// breaks the step and closes its own one-value run yields two runs, which
// the single output port of the queue passes on one at a time, so such a
// value can hold back the values behind it. Write max_run_length only while
// the encoder is idle; the sum is cleared only by reset.
module linear_run_encoder_core #(
	parameter int unsigned DATA_WIDTH  = 32,
	parameter int unsigned COUNT_WIDTH = 16
) (
	input  wire                           clk,
	input  wire                           arst_n,
	lre_col_if.sink                       col,
	lre_run_if.source                     run,
	input  wire                           cfg_we,
	input  wire [lre_pkg::CFG_WIDTH-1:0]  cfg_wdata
);

	localparam int unsigned LIM_WIDTH =
		(COUNT_WIDTH > lre_pkg::CFG_WIDTH) ? COUNT_WIDTH : lre_pkg::CFG_WIDTH;
	localparam logic [LIM_WIDTH-1:0] CNT_MAX_EXT = LIM_WIDTH'({COUNT_WIDTH{1'b1}});
	localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);
	localparam logic [COUNT_WIDTH-1:0] CNT_TWO = COUNT_WIDTH'(2);
	localparam logic [lre_pkg::QCNT_WIDTH-1:0] Q_FULL =
		lre_pkg::QCNT_WIDTH'(lre_pkg::QUEUE_DEPTH);

	// run limit register
	logic [lre_pkg::CFG_WIDTH-1:0] max_len_q;

	// input stage
	logic                  valid_s1;
	logic [DATA_WIDTH-1:0] value_s1;
	logic                  eoc_s1;

	// run state
	logic [DATA_WIDTH-1:0]  base_q;
	logic [DATA_WIDTH-1:0]  step_q;
	logic [DATA_WIDTH-1:0]  prev_q;
	logic [COUNT_WIDTH-1:0] count_q;
	logic [DATA_WIDTH-1:0]  sum_q;

	// result queue, entry 0 is the head
	logic [DATA_WIDTH-1:0]  qbase_q  [lre_pkg::QUEUE_DEPTH];
	logic [DATA_WIDTH-1:0]  qstep_q  [lre_pkg::QUEUE_DEPTH];
	logic [COUNT_WIDTH-1:0] qcount_q [lre_pkg::QUEUE_DEPTH];
	logic [DATA_WIDTH-1:0]  qsum_q   [lre_pkg::QUEUE_DEPTH];
	logic                   qlast_q  [lre_pkg::QUEUE_DEPTH];
	logic [lre_pkg::QCNT_WIDTH-1:0] qcnt_q;

	logic [DATA_WIDTH-1:0]  qbase_d  [lre_pkg::QUEUE_DEPTH];
	logic [DATA_WIDTH-1:0]  qstep_d  [lre_pkg::QUEUE_DEPTH];
	logic [COUNT_WIDTH-1:0] qcount_d [lre_pkg::QUEUE_DEPTH];
	logic [DATA_WIDTH-1:0]  qsum_d   [lre_pkg::QUEUE_DEPTH];
	logic                   qlast_d  [lre_pkg::QUEUE_DEPTH];
	logic [lre_pkg::QCNT_WIDTH-1:0] qcnt_d;

	// next-state signals
	logic [LIM_WIDTH-1:0]   lim_ext;
	logic [COUNT_WIDTH-1:0] limit;
	logic [DATA_WIDTH-1:0]  diff;
	logic [DATA_WIDTH-1:0]  base_n;
	logic [DATA_WIDTH-1:0]  step_n;
	logic [DATA_WIDTH-1:0]  prev_n;
	logic [COUNT_WIDTH-1:0] count_n;
	logic [DATA_WIDTH-1:0]  sum_n;
	logic                   emit_brk;
	logic                   emit_cls;
	logic [lre_pkg::QCNT_WIDTH-1:0] n_res;
	logic [lre_pkg::QCNT_WIDTH-1:0] qcnt_pop;
	logic                   pop;
	logic                   adv;
	logic                   col_acc;

	// handshake; occupancy check one bit wider so a full queue plus two runs cannot wrap
	assign pop      = run.ready && (qcnt_q != '0);
	assign qcnt_pop = qcnt_q - lre_pkg::QCNT_WIDTH'(pop);
	assign n_res    = lre_pkg::QCNT_WIDTH'(emit_brk) + lre_pkg::QCNT_WIDTH'(emit_cls);
	assign adv      = valid_s1 && (({1'b0, qcnt_pop} + {1'b0, n_res}) <= {1'b0, Q_FULL});
	assign col.ready = !valid_s1 || adv;
	assign col_acc  = col.valid && col.ready;

	// limit saturates at the largest count the counter can hold
	assign lim_ext = LIM_WIDTH'(max_len_q);
	assign limit   = (lim_ext > CNT_MAX_EXT) ? COUNT_WIDTH'(CNT_MAX_EXT)
	                                         : COUNT_WIDTH'(lim_ext);

	// run update for the held value
	always_comb begin
		diff     = value_s1 - prev_q;
		base_n   = base_q;
		step_n   = step_q;
		prev_n   = prev_q;
		count_n  = count_q;
		emit_brk = 1'b0;
		if (count_q == '0) begin
			base_n  = value_s1;
			step_n  = '0;
			prev_n  = value_s1;
			count_n = CNT_ONE;
		end else if (count_q == CNT_ONE) begin
			step_n  = diff;
			prev_n  = value_s1;
			count_n = CNT_TWO;
		end else if (diff == step_q) begin
			prev_n  = value_s1;
			count_n = count_q + CNT_ONE;
		end else begin
			// step broken: old run leaves, value opens a new one
			emit_brk = 1'b1;
			base_n   = value_s1;
			step_n   = '0;
			prev_n   = value_s1;
			count_n  = CNT_ONE;
		end
		sum_n    = sum_q + value_s1;
		emit_cls = eoc_s1 || (count_n >= limit);
	end

	// queue update: pop the head, then append this cycle's runs
	always_comb begin
		for (int i = 0; i < lre_pkg::QUEUE_DEPTH; i++) begin
			qbase_d[i]  = qbase_q[i];
			qstep_d[i]  = qstep_q[i];
			qcount_d[i] = qcount_q[i];
			qsum_d[i]   = qsum_q[i];
			qlast_d[i]  = qlast_q[i];
		end
		qcnt_d = qcnt_q;
		if (pop) begin
			qbase_d[0]  = qbase_q[1];
			qstep_d[0]  = qstep_q[1];
			qcount_d[0] = qcount_q[1];
			qsum_d[0]   = qsum_q[1];
			qlast_d[0]  = qlast_q[1];
			qcnt_d      = qcnt_pop;
		end
		if (adv && emit_brk) begin
			qbase_d[qcnt_d[0]]  = base_q;
			qstep_d[qcnt_d[0]]  = step_q;
			qcount_d[qcnt_d[0]] = count_q;
			qsum_d[qcnt_d[0]]   = sum_q;
			qlast_d[qcnt_d[0]]  = 1'b0;
			qcnt_d              = qcnt_d + lre_pkg::QCNT_WIDTH'(1);
		end
		if (adv && emit_cls) begin
			qbase_d[qcnt_d[0]]  = base_n;
			qstep_d[qcnt_d[0]]  = step_n;
			qcount_d[qcnt_d[0]] = count_n;
			qsum_d[qcnt_d[0]]   = sum_n;
			qlast_d[qcnt_d[0]]  = eoc_s1;
			qcnt_d              = qcnt_d + lre_pkg::QCNT_WIDTH'(1);
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= lre_pkg::CFG_RESET;
			valid_s1  <= 1'b0;
			base_q    <= '0;
			step_q    <= '0;
			prev_q    <= '0;
			count_q   <= '0;
			sum_q     <= '0;
			qcnt_q    <= '0;
		end else begin
			if (cfg_we) begin
				max_len_q <= cfg_wdata;
			end
			if (col_acc) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				base_q  <= base_n;
				step_q  <= emit_cls ? '0 : step_n;
				prev_q  <= prev_n;
				count_q <= emit_cls ? '0 : count_n;
				sum_q   <= sum_n;
			end
			qcnt_q <= qcnt_d;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (col_acc) begin
			value_s1 <= col.value;
			eoc_s1   <= col.end_of_column;
		end
		for (int i = 0; i < lre_pkg::QUEUE_DEPTH; i++) begin
			qbase_q[i]  <= qbase_d[i];
			qstep_q[i]  <= qstep_d[i];
			qcount_q[i] <= qcount_d[i];
			qsum_q[i]   <= qsum_d[i];
			qlast_q[i]  <= qlast_d[i];
		end
	end

	// result port shows the queue head
	assign run.valid     = (qcnt_q != '0);
	assign run.run_base  = qbase_q[0];
	assign run.run_step  = qstep_q[0];
	assign run.run_count = qcount_q[0];
	assign run.value_sum = qsum_q[0];
	assign run.last_run  = qlast_q[0];

endmodule

`default_nettype wire

// ===== src/lre_checker.sv =====
// Port-level checks for the linear run encoder, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module lre_checker #(
	parameter int unsigned DATA_WIDTH  = 32,
	parameter int unsigned COUNT_WIDTH = 16
) (
	input wire                          clk,
	input wire                          arst_n,
	input wire                          run_valid,
	input wire                          run_ready,
	input wire [DATA_WIDTH-1:0]         run_base,
	input wire [DATA_WIDTH-1:0]         run_step,
	input wire [COUNT_WIDTH-1:0]        run_count
);

	// a stalled transaction holds its run
	a_run_hold: assert property (@(posedge clk) disable iff (!arst_n)
		run_valid && !run_ready |=>
			run_valid && $stable(run_base) && $stable(run_step) && $stable(run_count))
		else $error("run transaction changed while stalled");

	// every run covers at least one value
	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		run_valid |-> run_count != '0)
		else $error("run with zero count");

	// a one-value run has no step
	a_single_step: assert property (@(posedge clk) disable iff (!arst_n)
		run_valid && (run_count == COUNT_WIDTH'(1)) |-> run_step == '0)
		else $error("one-value run with nonzero step");

	// result valid is always driven to a known level out of reset
	a_valid_known: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown(run_valid))
		else $error("run valid unknown");

endmodule

bind linear_run_encoder_core lre_checker #(
	.DATA_WIDTH (DATA_WIDTH),
	.COUNT_WIDTH(COUNT_WIDTH)
) u_lre_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.run_valid (run.valid),
	.run_ready (run.ready),
	.run_base  (run.run_base),
	.run_step  (run.run_step),
	.run_count (run.run_count)
);

`default_nettype wire

// ===== bench/tb_linear_run_encoder_core.sv =====
// Self-checking bench for the arithmetic-progression run encoder core.
`timescale 1ns / 1ps

module tb_linear_run_encoder_core;

	localparam int unsigned DATA_WIDTH     = 32;
	localparam int unsigned COUNT_WIDTH    = 16;
	localparam int unsigned DRAIN_CYCLES   = 6;
	localparam int unsigned WATCHDOG_LIMIT = 4000;
	localparam int unsigned LONG_RUN_VALS  = 200;
	localparam int unsigned PHASE_ITEMS    = 100;
	localparam int unsigned MAX_REPORTS    = 40;

	typedef struct packed {
		logic [DATA_WIDTH-1:0] value;
		logic                  eoc;
	} col_item_t;

	typedef struct packed {
		logic [DATA_WIDTH-1:0]  base;
		logic [DATA_WIDTH-1:0]  step;
		logic [COUNT_WIDTH-1:0] count;
		logic [DATA_WIDTH-1:0]  sum;
		logic                   last;
	} run_t;

	// Receiver stall patterns
	typedef enum logic [1:0] {
		SINK_STREAM,
		SINK_COIN,
		SINK_EVERY4,
		SINK_SPARSE
	} sink_mode_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [lre_pkg::CFG_WIDTH-1:0] cfg_wdata;

	lre_col_if #(.DATA_WIDTH(DATA_WIDTH)) col_ch ();
	lre_run_if #(.DATA_WIDTH(DATA_WIDTH), .COUNT_WIDTH(COUNT_WIDTH)) run_ch ();

	linear_run_encoder_core #(
		.DATA_WIDTH (DATA_WIDTH),
		.COUNT_WIDTH(COUNT_WIDTH)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.col      (col_ch),
		.run      (run_ch),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	// Stimulus and expected runs
	col_item_t col_pending[$];
	run_t      expected_runs[$];

	// Encoder mirror state
	logic [DATA_WIDTH-1:0]  mirror_base;
	logic [DATA_WIDTH-1:0]  mirror_step;
	logic [DATA_WIDTH-1:0]  mirror_prev;
	logic [COUNT_WIDTH-1:0] mirror_count;
	logic [DATA_WIDTH-1:0]  mirror_sum;
	logic [lre_pkg::CFG_WIDTH-1:0] mirror_limit;

	int unsigned mismatches;
	int unsigned values_sent;
	int unsigned runs_checked;
	int unsigned last_runs_seen;
	int unsigned settings_used;
	int unsigned quiet_cycles;

	logic        col_taken;
	int unsigned burst_left;
	int unsigned gap_left;
	sink_mode_t  sink_mode;
	int unsigned sink_mode_left;
	int unsigned sink_tick;

	// Clock
	initial clk = 1'b0;
	always #10 clk = ~clk;

	task automatic report_mismatch(input string what, input logic [DATA_WIDTH-1:0] got,
		input logic [DATA_WIDTH-1:0] want);
		if (mismatches < MAX_REPORTS)
			$display("[%0t] mismatch: %s got %h expected %h", $realtime, what, got, want);
		mismatches++;
	endtask

	task automatic check_field(input string what, input logic [DATA_WIDTH-1:0] got,
		input logic [DATA_WIDTH-1:0] want);
		if (got !== want)
			report_mismatch(what, got, want);
	endtask

	function automatic run_t closed_run(input logic last);
		run_t r;
		r.base  = mirror_base;
		r.step  = mirror_step;
		r.count = mirror_count;
		r.sum   = mirror_sum;
		r.last  = last;
		return r;
	endfunction

	// Fold one accepted value into the mirror and queue the runs it closes
	task automatic encode_value(input logic [DATA_WIDTH-1:0] v, input logic eoc);
		logic [DATA_WIDTH-1:0] diff;
		diff = v - mirror_prev;
		if (mirror_count == 0) begin
			mirror_base  = v;
			mirror_step  = '0;
			mirror_prev  = v;
			mirror_count = 1;
		end else if (mirror_count == 1) begin
			mirror_step  = diff;
			mirror_prev  = v;
			mirror_count = 2;
		end else if (diff == mirror_step) begin
			mirror_prev  = v;
			mirror_count = mirror_count + 1'b1;
		end else begin
			// step broken: close the open run before this value enters the sum
			expected_runs.push_back(closed_run(1'b0));
			mirror_base  = v;
			mirror_step  = '0;
			mirror_prev  = v;
			mirror_count = 1;
		end
		mirror_sum = mirror_sum + v;
		if (eoc || mirror_count >= mirror_limit) begin
			expected_runs.push_back(closed_run(eoc));
			mirror_count = '0;
			mirror_step  = '0;
		end
	endtask

	task automatic queue_value(input logic [DATA_WIDTH-1:0] v, input logic eoc);
		col_pending.push_back('{value: v, eoc: eoc});
	endtask

	// Mostly progressions with random base and step, some noise in between
	task automatic queue_random_column(input int unsigned n);
		int unsigned produced;
		int unsigned seg_len;
		int unsigned kind;
		logic [DATA_WIDTH-1:0] v;
		logic [DATA_WIDTH-1:0] stride;
		logic eoc;
		produced = 0;
		while (produced < n) begin
			kind = $urandom_range(0, 9);
			v = $urandom;
			case ($urandom_range(0, 4))
				0: stride = '0;
				1: stride = $urandom_range(0, 8) - 4;
				2: stride = $urandom;
				3: stride = 32'h8000_0000;
				default: stride = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'hFFFF_FFFF;
			endcase
			if (kind >= 8)
				seg_len = $urandom_range(1, 4);
			else if ($urandom_range(0, 15) == 0)
				seg_len = $urandom_range(20, 300);
			else
				seg_len = $urandom_range(1, 12);
			for (int unsigned i = 0; i < seg_len; i++) begin
				if (i == seg_len - 1)
					eoc = ($urandom_range(0, 3) == 0);
				else
					eoc = (kind >= 8) && ($urandom_range(0, 7) == 0);
				queue_value(v, eoc);
				v = (kind >= 8) ? $urandom : v + stride;
			end
			produced += seg_len;
		end
		// leave no run open across a register write
		col_pending[$].eoc = 1'b1;
	endtask

	task automatic wait_for_idle();
		forever begin
			@(negedge clk);
			#1;
			if (col_pending.size() == 0 && !col_ch.valid && expected_runs.size() == 0)
				break;
		end
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic set_run_limit(input logic [lre_pkg::CFG_WIDTH-1:0] lim);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= lim;
		@(negedge clk);
		cfg_we    <= 1'b0;
		settings_used++;
	endtask

	// Column sender: bursts of random length separated by random gaps
	always @(negedge clk) begin
		if (!arst_n) begin
			col_ch.valid <= 1'b0;
		end else if (!col_ch.valid || col_taken) begin
			if (gap_left != 0) begin
				gap_left--;
				col_ch.valid <= 1'b0;
			end else if (col_pending.size() != 0) begin
				col_ch.value         <= col_pending[0].value;
				col_ch.end_of_column <= col_pending[0].eoc;
				col_ch.valid         <= 1'b1;
				void'(col_pending.pop_front());
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 40);
					gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
				end else begin
					burst_left--;
				end
			end else begin
				col_ch.valid <= 1'b0;
			end
		end
	end

	// Run receiver: stall pattern switches between modes every so often
	always @(negedge clk) begin
		if (!arst_n) begin
			run_ch.ready <= 1'b0;
		end else begin
			if (sink_mode_left == 0) begin
				sink_mode      = sink_mode_t'($urandom_range(0, 3));
				sink_mode_left = $urandom_range(16, 200);
			end else begin
				sink_mode_left--;
			end
			sink_tick++;
			case (sink_mode)
				SINK_STREAM: run_ch.ready <= 1'b1;
				SINK_COIN:   run_ch.ready <= $urandom_range(0, 1);
				SINK_EVERY4: run_ch.ready <= (sink_tick % 4 == 0);
				default:     run_ch.ready <= ($urandom_range(0, 7) == 0);
			endcase
		end
	end

	// Monitor: check runs, predict from accepted values, watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			col_taken <= col_ch.valid && col_ch.ready;
			if (cfg_we)
				mirror_limit = cfg_wdata;
			if (run_ch.valid && run_ch.ready) begin
				runs_checked++;
				if (run_ch.last_run)
					last_runs_seen++;
				if (expected_runs.size() == 0) begin
					report_mismatch("run with nothing expected, base", run_ch.run_base, '0);
				end else begin
					check_field("run_base", run_ch.run_base, expected_runs[0].base);
					check_field("run_step", run_ch.run_step, expected_runs[0].step);
					check_field("run_count", DATA_WIDTH'(run_ch.run_count),
						DATA_WIDTH'(expected_runs[0].count));
					check_field("value_sum", run_ch.value_sum, expected_runs[0].sum);
					check_field("last_run", DATA_WIDTH'(run_ch.last_run),
						DATA_WIDTH'(expected_runs[0].last));
					void'(expected_runs.pop_front());
				end
			end
			if (col_ch.valid && col_ch.ready) begin
				values_sent++;
				encode_value(col_ch.value, col_ch.end_of_column);
			end
			if ((col_ch.valid && col_ch.ready) || (run_ch.valid && run_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("[%0t] timeout: no transaction for %0d cycles, %0d runs outstanding",
					$realtime, quiet_cycles, expected_runs.size());
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	// Reset, then the phases of stimulus
	initial begin
		logic [DATA_WIDTH-1:0] v;
		logic [DATA_WIDTH-1:0] stride;
		logic [lre_pkg::CFG_WIDTH-1:0] limits[$];

		arst_n               = 1'b0;
		cfg_we               = 1'b0;
		cfg_wdata            = '0;
		col_ch.valid         = 1'b0;
		col_ch.value         = '0;
		col_ch.end_of_column = 1'b0;
		run_ch.ready         = 1'b0;
		col_taken            = 1'b0;
		burst_left           = 0;
		gap_left             = 0;
		sink_mode            = SINK_STREAM;
		sink_mode_left       = 0;
		sink_tick            = 0;
		mismatches           = 0;
		values_sent          = 0;
		runs_checked         = 0;
		last_runs_seen       = 0;
		settings_used        = 0;
		quiet_cycles         = 0;
		mirror_base          = '0;
		mirror_step          = '0;
		mirror_prev          = '0;
		mirror_count         = '0;
		mirror_sum           = '0;
		mirror_limit         = lre_pkg::CFG_RESET;

		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// Directed: single-value column at the most negative value
		queue_value(32'h8000_0000, 1'b1);
		// step of one across the signed wrap, then a break
		queue_value(32'h7FFF_FFFF, 1'b0);
		queue_value(32'h8000_0000, 1'b0);
		queue_value(32'h8000_0001, 1'b0);
		// zero step run, then a value that breaks the step and ends the column
		queue_value(32'h0000_0005, 1'b0);
		queue_value(32'h0000_0005, 1'b0);
		queue_value(32'h0000_0005, 1'b0);
		queue_value(32'hFFFF_FFFF, 1'b1);
		// step of minus one across the signed wrap
		queue_value(32'h8000_0000, 1'b0);
		queue_value(32'h7FFF_FFFF, 1'b0);
		queue_value(32'h7FFF_FFFE, 1'b1);
		// step of 2^31 in both directions
		queue_value(32'h0000_0000, 1'b0);
		queue_value(32'h8000_0000, 1'b0);
		queue_value(32'h0000_0000, 1'b1);
		// two-value run at end of column
		queue_value(32'h0000_0001, 1'b0);
		queue_value(32'h0000_0003, 1'b1);
		// falling progression
		queue_value(32'd100, 1'b0);
		queue_value(32'd90, 1'b0);
		queue_value(32'd80, 1'b0);
		queue_value(32'd70, 1'b1);
		// largest positive value, then zero
		queue_value(32'h7FFF_FFFF, 1'b0);
		queue_value(32'h0000_0000, 1'b1);
		wait_for_idle();

		// One long progression cut into several runs by a mid-size limit
		set_run_limit(16'd64);
		v      = $urandom;
		stride = $urandom | 32'h1;
		for (int unsigned i = 0; i < LONG_RUN_VALS; i++) begin
			queue_value(v, i == LONG_RUN_VALS - 1);
			v = v + stride;
		end
		wait_for_idle();

		// Random columns under a range of limits, extremes included
		limits.push_back(16'd2);
		limits.push_back(16'd0);
		limits.push_back(16'd1);
		limits.push_back(16'd3);
		limits.push_back(16'hFFFF);
		limits.push_back(lre_pkg::CFG_WIDTH'($urandom_range(4, 12)));
		limits.push_back(lre_pkg::CFG_WIDTH'($urandom_range(13, 300)));
		limits.push_back(16'd2);
		foreach (limits[k]) begin
			set_run_limit(limits[k]);
			queue_random_column(PHASE_ITEMS);
			wait_for_idle();
		end

		$display("Coverage: %0d column values under %0d limit settings (0, 1, 2 and 65535 among them)",
			values_sent, settings_used);
		$display("Coverage: %0d runs compared, %0d of them closing a column, %0d mismatches",
			runs_checked, last_runs_seen, mismatches);
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
src/lre_pkg.sv
src/lre_if.sv
src/linear_run_encoder_core.sv
src/lre_checker.sv
bench/tb_linear_run_encoder_core.sv
